// ===== design/pwm_capture_freq_duty_defines.svh =====
// ----------------------------------------------------------------------------
// PWM capture assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PWM_CAPTURE_FREQ_DUTY_DEFINES_SVH
`define PWM_CAPTURE_FREQ_DUTY_DEFINES_SVH

// Same-cycle implication
`define PCFD_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwm capture: same-cycle check failed");

// Next-cycle implication
`define PCFD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwm capture: next-cycle check failed");

`endif

// ===== design/pcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM capture package
// Widths, reset values, phase codes and divider status shared by the block.
// ----------------------------------------------------------------------------
package pcfd_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int STAMP_W          = 16;
	localparam int TICK_W           = 27;
	localparam int PERIOD_W         = STAMP_W + 1;
	localparam int DUTY_W           = 16;
	localparam int DUTY_DVD_W       = STAMP_W + DUTY_W;

	localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(1000000);

	localparam logic [1:0] PH_RISE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	typedef struct packed {
		logic busy;
		logic last_step;
	} div_stat_t;

endpackage

// ===== design/pwm_capture_freq_duty.sv =====
// ----------------------------------------------------------------------------
// PWM input capture, frequency and duty cycle
// Rising and falling captures pass through S_EMIT on their way to out_valid.
// A period-closing capture with a nonzero period waits first in S_DIV for the
// 32-step serial duty divider. One capture in flight: in_ready returns with
// out_valid, and a waiting output word holds the emit.
// Async reset clears phase, stamp, widths, tick_rate (1000000) and all handshakes.
// ----------------------------------------------------------------------------
`include "pwm_capture_freq_duty_defines.svh"

module pwm_capture_freq_duty #(
	parameter int COUNTER_BITS = pcfd_pkg::COUNTER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pcfd_pkg::TICK_W-1:0]  tick_rate,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pcfd_pkg::STAMP_W-1:0] capture_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         next_edge_falling,
	output logic                         result_valid,
	output logic                         equal_capture,
	output logic [pcfd_pkg::STAMP_W-1:0] high_width,
	output logic [pcfd_pkg::STAMP_W-1:0] low_width,
	output logic [pcfd_pkg::TICK_W-1:0]  frequency,
	output logic [pcfd_pkg::DUTY_W-1:0]  duty_fraction
);
	import pcfd_pkg::*;

	localparam int SB = (COUNTER_BITS < STAMP_W) ? COUNTER_BITS : STAMP_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [1:0]             phase_q;
	logic [SB-1:0]          last_stamp_q;
	logic [STAMP_W-1:0]     high_q;
	logic [STAMP_W-1:0]     low_q;
	logic [TICK_W-1:0]      tick_rate_q;
	logic                   start_q;
	logic                   out_valid_q;
	logic                   falling_q;
	logic                   equal_q;
	logic                   rvalid_q;

	logic                   accept;
	logic [SB-1:0]          stamp;
	logic                   same;
	logic [STAMP_W-1:0]     width_new;
	logic [STAMP_W-1:0]     low_nxt;
	logic                   period_nz;
	logic [PERIOD_W-1:0]    period;
	logic                   out_free;
	logic [TICK_W-1:0]      freq_quo;
	logic [DUTY_DVD_W-1:0]  duty_quo;
	logic [DUTY_W-1:0]      duty_sat;
	div_stat_t              freq_stat;
	div_stat_t              duty_stat;

	assign accept    = in_valid && in_ready;
	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign stamp     = capture_time[SB-1:0];
	assign same      = stamp == last_stamp_q;
	assign width_new = STAMP_W'(SB'(stamp - last_stamp_q));
	assign low_nxt   = same ? low_q : width_new;
	assign period_nz = (high_q != '0) || (low_nxt != '0);
	assign period    = PERIOD_W'(high_q) + PERIOD_W'(low_q);

	// fraction 1.0 only arises with zero low time: clamp it
	assign duty_sat = (duty_quo[DUTY_DVD_W-1:DUTY_W] != '0) ? '1 : duty_quo[DUTY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_rate_q <= tick_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_RISE;
			last_stamp_q <= '0;
			high_q       <= '0;
			low_q        <= '0;
			start_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			falling_q    <= 1'b0;
			equal_q      <= 1'b0;
			rvalid_q     <= 1'b0;
		end else begin
			// launch both dividers the cycle after a period-closing capture
			start_q <= accept && phase_q == PH_LOW && period_nz;
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_stamp_q <= stamp;
						unique case (phase_q)
							PH_HIGH: begin
								if (!same) begin
									high_q <= width_new;
								end
								equal_q   <= same;
								falling_q <= 1'b0;
								rvalid_q  <= 1'b0;
								phase_q   <= PH_LOW;
								state_q   <= S_EMIT;
							end
							PH_LOW: begin
								low_q     <= low_nxt;
								equal_q   <= same;
								falling_q <= 1'b0;
								rvalid_q  <= period_nz;
								phase_q   <= PH_RISE;
								state_q   <= period_nz ? S_DIV : S_EMIT;
							end
							default: begin
								equal_q   <= 1'b0;
								falling_q <= 1'b1;
								rvalid_q  <= 1'b0;
								phase_q   <= PH_HIGH;
								state_q   <= S_EMIT;
							end
						endcase
					end
				end
				S_DIV: begin
					if (!start_q && !freq_stat.busy && !duty_stat.busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			next_edge_falling <= falling_q;
			result_valid      <= rvalid_q;
			equal_capture     <= equal_q;
			high_width        <= high_q;
			low_width         <= low_q;
			frequency         <= rvalid_q ? freq_quo : '0;
			duty_fraction     <= rvalid_q ? duty_sat : '0;
		end
	end

	pcfd_div #(
		.DIVIDEND_W (TICK_W),
		.DIVISOR_W  (PERIOD_W)
	) u_freq_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (tick_rate_q),
		.divisor  (period),
		.stat     (freq_stat),
		.quotient (freq_quo)
	);

	pcfd_div #(
		.DIVIDEND_W (DUTY_DVD_W),
		.DIVISOR_W  (PERIOD_W)
	) u_duty_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend ({high_q, {DUTY_W{1'b0}}}),
		.divisor  (period),
		.stat     (duty_stat),
		.quotient (duty_quo)
	);

	`PCFD_ASSERT_IMPLY(a_idle_div_free, in_ready, !freq_stat.busy && !duty_stat.busy)
	`PCFD_ASSERT_NEXT(a_div_launch, accept && phase_q == PH_LOW && period_nz, state_q == S_DIV && start_q)
	`PCFD_ASSERT_IMPLY(a_no_result_zero, out_valid && !result_valid, frequency == '0 && duty_fraction == '0)
	`PCFD_ASSERT_NEXT(a_div_finish, duty_stat.last_step, !duty_stat.busy)

endmodule

// ===== design/pcfd_div.sv =====
// ----------------------------------------------------------------------------
// PWM capture serial divider
// Restoring divider, one quotient bit per cycle, giving a DIVIDEND_W-bit quotient.
// ----------------------------------------------------------------------------
module pcfd_div #(
	parameter int DIVIDEND_W = 27,
	parameter int DIVISOR_W  = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output pcfd_pkg::div_stat_t   stat,
	output logic [DIVIDEND_W-1:0] quotient
);
	import pcfd_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// bring down the next dividend bit and try the subtract
	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign stat.busy      = cnt_q != '0;
	assign stat.last_step = cnt_q == CNT_W'(1);
	assign quotient       = dvd_q;

endmodule

// ===== tb/sv/pwm_capture_freq_duty_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM capture frequency and duty testbench
// Feeds capture stamps through the rise/high/low cycle, tracks the expected
// widths, frequency and duty in a local model, and checks every output word
// in order under random source gaps, sink stalls and tick_rate changes.
// ----------------------------------------------------------------------------
module pwm_capture_freq_duty_test;
	import pcfd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 10;
	localparam logic [TICK_W-1:0] RATE_MAX = {TICK_W{1'b1}};

	typedef struct packed {
		logic                falling;
		logic                valid;
		logic                equal;
		logic [STAMP_W-1:0]  high;
		logic [STAMP_W-1:0]  low;
		logic [TICK_W-1:0]   freq;
		logic [DUTY_W-1:0]   duty;
	} pwm_reading_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TICK_W-1:0]   tick_rate = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [STAMP_W-1:0]  capture_time = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                next_edge_falling;
	logic                result_valid;
	logic                equal_capture;
	logic [STAMP_W-1:0]  high_width;
	logic [STAMP_W-1:0]  low_width;
	logic [TICK_W-1:0]   frequency;
	logic [DUTY_W-1:0]   duty_fraction;

	// model of the capture state
	logic [1:0]          model_phase = PH_RISE;
	logic [STAMP_W-1:0]  model_stamp = '0;
	logic [STAMP_W-1:0]  model_high = '0;
	logic [STAMP_W-1:0]  model_low = '0;
	logic [TICK_W-1:0]   model_rate = TICK_RATE_RESET;

	pwm_reading_t        pending_readings[$];
	int                  mismatch_count = 0;
	int                  cycle_count = 0;
	int                  stall_left = 0;
	bit                  source_gaps = 1'b0;
	bit                  sink_stalls = 1'b0;

	pwm_capture_freq_duty dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.tick_rate         (tick_rate),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.capture_time      (capture_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.next_edge_falling (next_edge_falling),
		.result_valid      (result_valid),
		.equal_capture     (equal_capture),
		.high_width        (high_width),
		.low_width         (low_width),
		.frequency         (frequency),
		.duty_fraction     (duty_fraction)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Advance the capture model by one stamp and return the word it produces.
	function automatic pwm_reading_t predict_reading(input logic [STAMP_W-1:0] stamp);
		pwm_reading_t r;
		logic [PERIOD_W-1:0] period;
		logic [31:0] quotient;
		r = '0;
		case (model_phase)
			PH_HIGH: begin
				r.equal = (stamp == model_stamp);
				if (!r.equal)
					model_high = stamp - model_stamp;
				model_stamp = stamp;
				model_phase = PH_LOW;
			end
			PH_LOW: begin
				r.equal = (stamp == model_stamp);
				if (!r.equal)
					model_low = stamp - model_stamp;
				model_stamp = stamp;
				model_phase = PH_RISE;
				period = {1'b0, model_high} + model_low;
				if (period != 0) begin
					r.valid = 1'b1;
					r.freq = model_rate / period;
					quotient = {model_high, 16'h0000} / period;
					// full duty comes out as 1.0, clamp to the largest fraction
					r.duty = (quotient > 32'h0000_FFFF) ? 16'hFFFF : quotient[15:0];
				end
			end
			default: begin
				// the unused phase code behaves like the rising phase
				model_stamp = stamp;
				r.falling = 1'b1;
				model_phase = PH_HIGH;
			end
		endcase
		r.high = model_high;
		r.low = model_low;
		return r;
	endfunction

	function automatic logic [STAMP_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return STAMP_W'($urandom_range(1, 16));
			3: return STAMP_W'($urandom_range(16'hFF00, 16'hFFFF));
			default: return STAMP_W'($urandom_range(1, 16'hFFFF));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the stamp is accepted.
	task automatic capture_edge(input logic [STAMP_W-1:0] stamp);
		int gap;
		if (source_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		capture_time <= stamp;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(predict_reading(stamp));
		@(negedge clk);
	endtask

	task automatic capture_period(input logic [STAMP_W-1:0] rise,
			input logic [STAMP_W-1:0] high_ticks, input logic [STAMP_W-1:0] low_ticks);
		capture_edge(rise);
		capture_edge(rise + high_ticks);
		capture_edge(rise + high_ticks + low_ticks);
	endtask

	// Drop valid and hold until every expected word has come back.
	task automatic wait_settled();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_tick_rate(input logic [TICK_W-1:0] rate);
		wait_settled();
		cfg_valid <= 1'b1;
		tick_rate <= rate;
		do @(posedge clk); while (!cfg_ready);
		model_rate = rate;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pwm_reading_t got;
		pwm_reading_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{next_edge_falling, result_valid, equal_capture, high_width,
				low_width, frequency, duty_fraction};
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected word: fall=%0d valid=%0d eq=%0d high=%0d low=%0d freq=%0d duty=%0d",
						got.falling, got.valid, got.equal, got.high, got.low, got.freq, got.duty);
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mismatch want: fall=%0d valid=%0d eq=%0d high=%0d low=%0d freq=%0d duty=%0d",
							want.falling, want.valid, want.equal, want.high, want.low,
							want.freq, want.duty);
						$display("          got: fall=%0d valid=%0d eq=%0d high=%0d low=%0d freq=%0d duty=%0d",
							got.falling, got.valid, got.equal, got.high, got.low,
							got.freq, got.duty);
					end
				end
			end
		end
	end

	// Zero period, full duty, wrapped stamps and the widest period at reset rate.
	task automatic test_special_periods();
		capture_period(16'h0000, 16'h0000, 16'h0000);
		capture_period(16'd100, 16'd200, 16'h0000);
		capture_period(16'hFFF0, 16'h0020, 16'h0010);
		capture_period(16'hFFFF, 16'hFFFF, 16'hFFFF);
		capture_period(16'h0000, 16'h0001, 16'h0001);
	endtask

	task automatic test_rate_extremes();
		write_tick_rate(RATE_MAX);
		capture_period(16'h1234, 16'h0001, 16'h0001);
		capture_period(16'hABCD, 16'h0001, 16'h0000);
		write_tick_rate(TICK_W'(1));
		capture_period(16'h5555, 16'h0000, 16'h0001);
		capture_period(16'hAAAA, 16'h8000, 16'h7FFF);
		write_tick_rate('0);
		capture_period(16'h0F0F, 16'h0003, 16'h0005);
		write_tick_rate(TICK_RATE_RESET);
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		logic [STAMP_W-1:0] lone;
		sent = 0;
		while (sent < n_items) begin
			if (sent % 64 < 3) begin
				source_gaps = $urandom_range(0, 1);
				sink_stalls = $urandom_range(0, 1);
			end
			if (sent % 200 < 3 && sent != 0) begin
				case ($urandom_range(0, 4))
					0: write_tick_rate(TICK_W'(1));
					1: write_tick_rate(RATE_MAX);
					2: write_tick_rate(TICK_RATE_RESET);
					default: write_tick_rate(TICK_W'($urandom_range(1, RATE_MAX)));
				endcase
			end
			if ($urandom_range(0, 11) == 0) begin
				// broken sequence: a stray stamp shifts the phase
				lone = STAMP_W'($urandom_range(0, 16'hFFFF));
				capture_edge(lone);
				sent++;
			end else begin
				while (model_phase != PH_RISE) begin
					capture_edge(STAMP_W'($urandom_range(0, 16'hFFFF)));
					sent++;
				end
				capture_period(STAMP_W'($urandom_range(0, 16'hFFFF)), pick_width(),
					pick_width());
				sent += 3;
			end
		end
	endtask

	task automatic test_steady_stream(input int n_periods);
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		write_tick_rate(TICK_W'($urandom_range(1, RATE_MAX)));
		repeat (n_periods)
			capture_period(STAMP_W'($urandom_range(0, 16'hFFFF)), pick_width(), pick_width());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_special_periods();
		test_rate_extremes();
		test_random_traffic(850);
		test_steady_stream(50);
		wait_settled();
		// catch stray words after the last expected one
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
